// ===== hdl/sitd_pkg.sv =====
// Shared constants and helpers for the signed integer to decimal text block.
// No dependencies; every other file in this folder imports this package.
package sitd_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int CHAR_BITS      = 6;
   localparam int DIGIT_BITS     = 4;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;

   // Number of decimal digits in the largest magnitude, 2^(bits-1).
   function automatic int dec_digits(input int bits);
      logic [63:0] v;
      int          n;
      v = 64'd1 << (bits - 1);
      n = 1;
      while (v >= 64'd10) begin
         v = v / 64'd10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

// ===== hdl/sitd_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on sitd_pkg for default widths.
interface sitd_req_if
   import sitd_pkg::*;
   #(parameter int VALUE_BITS = VALUE_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitd_rsp_if
   import sitd_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] ascii_char;
   logic                 last_char;
   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== hdl/signed_int_to_decimal_ascii_top.sv =====
// Top level: signed integer to decimal ASCII characters, one beat per character.
// Depends on sitd_pkg, sitd_if.sv and sitd_dabble_step.
// Per value: an accept state, VALUE_BITS double-dabble steps, a sign beat when
// negative, a skip of leading zero digits (the last digit always stays), then
// one beat per digit; sign and digit beats wait while the receiver stalls.
// Synchronous active-high reset returns the block to idle with no beat pending.
module signed_int_to_decimal_ascii_top
   import sitd_pkg::*;
   #(parameter int VALUE_BITS = VALUE_BITS_DEF)
   (
   input  logic       clock,
   input  logic       reset,
   sitd_req_if.sink   req_bus,
   sitd_rsp_if.source rsp_bus
   );

   localparam int NDIG  = dec_digits(VALUE_BITS);
   localparam int BCD_W = NDIG * DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_W = $clog2(NDIG + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [BCD_W-1:0]      bcd_ff;
   logic [BCD_W-1:0]      bcd_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIG_W-1:0]      dig_ff;
   logic                  neg_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff;
   logic                  rsp_last_ff;
   logic [DIGIT_BITS-1:0] top_digit;
   logic                  out_free;

   sitd_dabble_step #(.DIGITS(NDIG)) u_step (
      .bcd_cur  (bcd_ff),
      .bit_in   (bin_ff[VALUE_BITS-1]),
      .bcd_next (bcd_in)
   );

   assign top_digit         = bcd_ff[BCD_W-1 -: DIGIT_BITS];
   assign out_free          = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.ascii_char = rsp_char_ff;
   assign rsp_bus.last_char = rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if ((state_ff == ST_SIGN || state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  neg_ff   <= req_bus.value[VALUE_BITS-1];
                  bin_ff   <= req_bus.value[VALUE_BITS-1] ?
                              (~req_bus.value + 1'b1) : req_bus.value;
                  bcd_ff   <= '0;
                  cnt_ff   <= CNT_W'(VALUE_BITS);
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff <= bcd_in;
               bin_ff <= {bin_ff[VALUE_BITS-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  dig_ff   <= DIG_W'(NDIG);
                  state_ff <= neg_ff ? ST_SIGN : ST_SKIP;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_char_ff  <= CHAR_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_SKIP;
               end
            end
            ST_SKIP: begin
               if (top_digit == '0 && dig_ff > DIG_W'(1)) begin
                  bcd_ff <= bcd_ff << DIGIT_BITS;
                  dig_ff <= dig_ff - 1'b1;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_char_ff  <= CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit};
                  rsp_last_ff  <= (dig_ff == DIG_W'(1));
                  bcd_ff       <= bcd_ff << DIGIT_BITS;
                  dig_ff       <= dig_ff - 1'b1;
                  if (dig_ff == DIG_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/sitd_dabble_step.sv =====
// One double-dabble step: add three to every BCD digit of five or more, then
// shift the register left by one bit. Depends on sitd_pkg.
module sitd_dabble_step
   import sitd_pkg::*;
   #(parameter int DIGITS = dec_digits(VALUE_BITS_DEF))
   (
   input  logic [DIGITS*DIGIT_BITS-1:0] bcd_cur,
   input  logic                         bit_in,
   output logic [DIGITS*DIGIT_BITS-1:0] bcd_next
   );

   localparam int BCD_W = DIGITS * DIGIT_BITS;

   logic [BCD_W-1:0] adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_cur[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_cur[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
         end else begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_cur[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   assign bcd_next = {adj[BCD_W-2:0], bit_in};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for signed_int_to_decimal_ascii_top: integer beats in, character beats out.
// Depends on sitd_pkg, the channel interfaces in hdl/sitd_if.sv and the block itself.
module tb;
   import sitd_pkg::*;

   localparam int VALUE_BITS = 32;
   localparam int IDLE_PCT   = 38;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic [CHAR_BITS-1:0]         code;
      logic                         last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   sitd_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   sitd_rsp_if                            rsp_bus ();

   signed_int_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_char_type pending_chars[$];
   int         values_sent   = 0;
   int         chars_checked = 0;
   int         error_count   = 0;
   int         hold_cycles   = 0;
   bit         no_idle       = 1'b0;

   always #4 clock = ~clock;

   function automatic void queue_decimal_text(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digits[$];
      text_char_type         c;
      mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      do begin
         digits.push_front(4'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      c.value = value;
      if (value[VALUE_BITS-1]) begin
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
         c.code = CHAR_ZERO + digits[i];
         c.last = (i == digits.size() - 1);
         pending_chars.push_back(c);
      end
   endfunction

   task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      queue_decimal_text(value);
      values_sent++;
   endtask

   // Character beats are checked here; ready idles at random or holds off on request.
   initial begin
      text_char_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got char %0d last %0b",
                        $realtime, rsp_bus.ascii_char, rsp_bus.last_char);
               error_count++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_bus.ascii_char !== want.code) begin
                  $display("%0t: value %0d: char expected %0d, actual %0d",
                           $realtime, want.value, want.code, rsp_bus.ascii_char);
                  error_count++;
               end
               if (rsp_bus.last_char !== want.last) begin
                  $display("%0t: value %0d: last_char expected %0b, actual %0b",
                           $realtime, want.value, want.last, rsp_bus.last_char);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic test_directed();
      logic signed [VALUE_BITS-1:0] values[] = '{
         0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
         2147483647, 32'sh8000_0000, -2147483647, 2147483646,
         1000000000, -1000000000, 999999999, -999999999,
         123456789, -123456789, 32'sh5555_5555, 32'shAAAA_AAAA,
         1000000, -7, 42
      };
      foreach (values[i]) send_value(values[i]);
   endtask

   // Magnitudes spread evenly over the digit counts, with random sign, and now and then the most negative value.
   task automatic test_digit_lengths(input int count);
      int                           ndig;
      longint                       lo;
      longint                       hi;
      logic [VALUE_BITS-1:0]        mag;
      logic signed [VALUE_BITS-1:0] value;
      repeat (count) begin
         ndig = $urandom_range(10, 1);
         lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
         hi   = (ndig == 10) ? 64'd2147483647 : 10 ** ndig - 1;
         mag  = $urandom_range(32'(hi), 32'(lo));
         if ($urandom_range(7) == 0) begin
            value = 32'sh8000_0000;
         end else if ($urandom_range(1)) begin
            value = -mag;
         end else begin
            value = mag;
         end
         send_value(value);
      end
   endtask

   task automatic test_full_range(input int count);
      repeat (count) send_value($urandom);
   endtask

   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      repeat (count) send_value($urandom);
      no_idle = 1'b0;
   endtask

   // The receiver stops for a long time while values keep coming, so the input stalls.
   task automatic test_output_stall(input int count);
      hold_cycles = 400;
      no_idle     = 1'b1;
      repeat (count) send_value($urandom_range(1) ? $urandom : $urandom_range(999));
      no_idle     = 1'b0;
   endtask

   task automatic wait_for_drain();
      @(posedge clock);
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_digit_lengths(175);
      test_full_range(100);
      test_back_to_back(60);
      test_output_stall(40);
      test_digit_lengths(20);
      wait_for_drain();

      $display("Converted %0d values into %0d character beats: extremes, every digit count,",
               values_sent, chars_checked);
      $display("random signs, back-to-back traffic and a long output stall.");
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Timeout with %0d character beats still expected.", pending_chars.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
